/* rtl/vrr_pkg.sv */
// vrr_pkg: shared types and constants of the volume rotate resampler
// no dependencies; used by the top level by scoped names
`default_nettype none

package vrr_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COORD,
    ST_TAPS,
    ST_KA,
    ST_KB,
    ST_ADR,
    ST_RD,
    ST_MY,
    ST_MX,
    ST_MR,
    ST_MZ,
    ST_FIN,
    ST_DONE
  } vrr_state_e;

  // configuration register indexes
  localparam logic [2:0] CFG_ROT_X     = 3'd0;
  localparam logic [2:0] CFG_ROT_Y     = 3'd1;
  localparam logic [2:0] CFG_ROT_Z     = 3'd2;
  localparam logic [2:0] CFG_IN_DIMS   = 3'd3;
  localparam logic [2:0] CFG_OUT_DIMS  = 3'd4;
  localparam logic [2:0] CFG_MODE      = 3'd5;
  localparam logic [2:0] CFG_FILL      = 3'd6;

  // interpolation modes, the reserved code runs as cubic
  localparam logic [1:0] MODE_NEAREST  = 2'd0;
  localparam logic [1:0] MODE_LINEAR   = 2'd1;
  localparam logic [1:0] MODE_CUBIC    = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic [47:0] ROT_X_RESET  = 48'h4000_0000_0000;
  localparam logic [47:0] ROT_Y_RESET  = 48'h0000_4000_0000;
  localparam logic [47:0] ROT_Z_RESET  = 48'h0000_0000_4000;
  localparam logic [23:0] DIMS_RESET   = 24'h40_40_40;

  localparam int unsigned ONE_Q14      = 16384;
  localparam int unsigned TWO_Q14      = 32768;
  localparam int unsigned FIVE_Q14     = 81920;
  localparam int unsigned HALF_Q14     = 8192;

endpackage

`default_nettype wire

/* rtl/vrr_if.sv */
// vrr_in_if / vrr_out_if: valid-ready channels of the resampler
// no dependencies
`default_nettype none

interface vrr_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [17:0] voxel_addr;
  logic [15:0] voxel_value;
  logic [7:0]  out_col;
  logic [7:0]  out_row;
  logic [7:0]  out_page;
  modport source (output valid, kind, voxel_addr, voxel_value, out_col, out_row, out_page,
                  input ready);
  modport sink   (input valid, kind, voxel_addr, voxel_value, out_col, out_row, out_page,
                  output ready);
endinterface

interface vrr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_value;
  logic        clipped;
  modport source (output valid, sample_value, clipped, input ready);
  modport sink   (input valid, sample_value, clipped, output ready);
endinterface

`default_nettype wire

/* rtl/vrr_voxel_ram.sv */
// vrr_voxel_ram: single write port, single registered read port voxel memory
// no dependencies
`default_nettype none

module vrr_voxel_ram #(
  parameter int unsigned DEPTH  = 262144,
  parameter int unsigned ADDR_W = 18,
  parameter int unsigned DATA_W = 16
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/volume_rotate_resampler.sv */
// volume_rotate_resampler: loads a voxel volume, then inverse-rotates and resamples
// a load word is written in idle; a sample word runs the coordinate, tap, address,
// read, multiply and rounding states (keys weight states too in cubic mode), all
// on the shared multiplier and the single read port; no new word is taken meanwhile;
// ready is high only in idle; a full output register holds the block in its last state
// reset (async, active low) restores the config defaults; the memory is not cleared
// depends on vrr_pkg, vrr_if, vrr_voxel_ram
`default_nettype none

module volume_rotate_resampler #(
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_DEPTH  = 64,
  parameter int unsigned VOXEL_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  vrr_in_if.sink           in_i,
  vrr_out_if.source        out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [47:0] cfg_data_i
);

  localparam int unsigned STORE  = MAX_HEIGHT * MAX_WIDTH * MAX_DEPTH;
  localparam int unsigned ADDR_W = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int unsigned XW     = (VOXEL_BITS + 20 > 34) ? VOXEL_BITS + 20 : 34;
  localparam int unsigned ACW    = XW + 18;
  localparam int unsigned CW     = 28;
  localparam int unsigned TW     = 16;
  localparam logic signed [ACW-1:0] C13  = ACW'(64'sh0000_0000_0000_2000);
  localparam logic signed [ACW-1:0] C27  = ACW'(64'sh0000_0000_0800_0000);
  localparam logic signed [ACW-1:0] C28  = ACW'(64'sh0000_0000_1000_0000);
  localparam logic signed [ACW-1:0] C31  = ACW'(64'sh0000_0000_8000_0000);
  localparam logic signed [ACW-1:0] C43  = ACW'(64'sh0000_0800_0000_0000);
  localparam logic signed [ACW-1:0] C44  = ACW'(64'sh0000_1000_0000_0000);
  localparam logic signed [ACW-1:0] VMAX = ACW'((65'd1 << VOXEL_BITS) - 65'd1);

  vrr_pkg::vrr_state_e state_q, state_d;

  logic [47:0] rotx_q, roty_q, rotz_q;
  logic [23:0] indims_q, outdims_q;
  logic [1:0]  mode_q;
  logic [15:0] fill_q;

  logic [1:0] ax_q, ax_d, tm_q, tm_d, ti_q, ti_d, tj_q, tj_d, tk_q, tk_d;
  logic        ov_q, ov_d;

  logic signed [10:0]     d2_q [3], d2_d [3];
  logic signed [ACW-1:0]  acc_q, acc_d, accy_q, accy_d, accx_q, accx_d, accz_q, accz_d;
  logic signed [CW-1:0]   coord_q [3], coord_d [3];
  logic signed [TW-1:0]   first_q [3], first_d [3];
  logic signed [15:0]     wt_q [3][4], wt_d [3][4];
  logic [16:0]            hw_q, hw_d;
  logic [ADDR_W-1:0]      addrz_q, addrz_d, addrx_q, addrx_d, addr_q, addr_d;
  logic signed [XW-1:0]   sxy_q, sxy_d;
  logic [15:0]            rsv_q, rsv_d, osv_q, osv_d;
  logic                   rcl_q, rcl_d, ocl_q, ocl_d;
  logic                   ins_q, ins_d;

  logic signed [XW-1:0]  mul_x;
  logic signed [17:0]    mul_y;
  logic signed [ACW-1:0] mul_p;

  logic [7:0]  dim_h, dim_w, dim_d;
  logic [1:0]  last_tap;
  logic        ram_we;
  logic [ADDR_W-1:0] rd_addr;
  logic [VOXEL_BITS-1:0] rdata;

  // saturated input dimensions and the last tap index of the mode
  always_comb begin
    dim_h = (9'({1'b0, indims_q[23:16]}) > 9'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : indims_q[23:16];
    dim_w = (9'({1'b0, indims_q[15:8]}) > 9'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : indims_q[15:8];
    dim_d = (9'({1'b0, indims_q[7:0]}) > 9'(MAX_DEPTH)) ? 8'(MAX_DEPTH) : indims_q[7:0];
    case (mode_q)
      vrr_pkg::MODE_NEAREST: last_tap = 2'd0;
      vrr_pkg::MODE_LINEAR:  last_tap = 2'd1;
      default:               last_tap = 2'd3;
    endcase
  end

  assign mul_p = mul_x * mul_y;
  assign in_i.ready = (state_q == vrr_pkg::ST_IDLE);
  assign out_o.valid = ov_q;
  assign out_o.sample_value = osv_q;
  assign out_o.clipped = ocl_q;

  always_comb begin
    logic [47:0]           row;
    logic [8:0]            centre;
    logic signed [ACW-1:0] sum, num, rres;
    logic signed [CW-1:0]  c;
    logic [13:0]           fr;
    logic [16:0]           ka;
    logic                  br1;
    logic [1:0]            si;
    logic signed [TW:0]    tx, ty, tz;
    state_d = state_q;
    ax_d = ax_q;
    tm_d = tm_q;
    ti_d = ti_q;
    tj_d = tj_q;
    tk_d = tk_q;
    d2_d = d2_q;
    acc_d = acc_q;
    coord_d = coord_q;
    first_d = first_q;
    wt_d = wt_q;
    hw_d = hw_q;
    addrz_d = addrz_q;
    addrx_d = addrx_q;
    addr_d = addr_q;
    accy_d = accy_q;
    accx_d = accx_q;
    accz_d = accz_q;
    sxy_d = sxy_q;
    rsv_d = rsv_q;
    rcl_d = rcl_q;
    osv_d = osv_q;
    ocl_d = ocl_q;
    ov_d = ov_q && !out_o.ready;
    ram_we = 1'b0;
    mul_x = '0;
    mul_y = '0;
    rd_addr = addr_q;
    si = ti_q;

    case (ax_q)
      2'd0:    begin row = rotx_q; centre = {1'b0, dim_w} + 9'd1; end
      2'd1:    begin row = roty_q; centre = {1'b0, dim_h} + 9'd1; end
      default: begin row = rotz_q; centre = {1'b0, dim_d} + 9'd1; end
    endcase
    fr = coord_q[ax_q][13:0];
    case (tm_q)
      2'd0:    ka = 17'(vrr_pkg::ONE_Q14) + 17'(fr);
      2'd1:    ka = 17'(fr);
      2'd2:    ka = 17'(vrr_pkg::ONE_Q14) - 17'(fr);
      default: ka = 17'(vrr_pkg::TWO_Q14) - 17'(fr);
    endcase
    br1 = (ka < 17'(vrr_pkg::ONE_Q14));
    sum = '0;
    num = '0;
    rres = '0;
    c = '0;

    case (state_q)
      vrr_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          if (!in_i.kind) begin
            ram_we = (32'(in_i.voxel_addr) < 32'(STORE));
          end else begin
            d2_d[0] = 11'({2'b0, in_i.out_col, 1'b0}) - 11'(outdims_q[15:8]) - 11'd1;
            d2_d[1] = 11'({2'b0, in_i.out_row, 1'b0}) - 11'(outdims_q[23:16]) - 11'd1;
            d2_d[2] = 11'({2'b0, in_i.out_page, 1'b0}) - 11'(outdims_q[7:0]) - 11'd1;
            ax_d = 2'd0;
            tm_d = 2'd0;
            state_d = vrr_pkg::ST_COORD;
          end
        end
      end
      // centre + row . delta, exact in 15 fraction bits
      vrr_pkg::ST_COORD: begin
        mul_x = XW'(d2_q[tm_q]);
        case (tm_q)
          2'd0:    mul_y = 18'($signed(row[47:32]));
          2'd1:    mul_y = 18'($signed(row[31:16]));
          default: mul_y = 18'($signed(row[15:0]));
        endcase
        sum = ((tm_q == 2'd0) ? ACW'({centre, 14'b0}) : acc_q) + mul_p;
        if (tm_q == 2'd2) begin
          coord_d[ax_q] = CW'((sum + 1) >>> 1);
          tm_d = 2'd0;
          ax_d = ax_q + 2'd1;
          if (ax_q == 2'd2) begin
            state_d = vrr_pkg::ST_TAPS;
          end
        end else begin
          acc_d = sum;
          tm_d = tm_q + 2'd1;
        end
      end
      vrr_pkg::ST_TAPS: begin
        for (int a = 0; a < 3; a++) begin
          c = coord_q[a];
          case (mode_q)
            vrr_pkg::MODE_NEAREST: begin
              first_d[a] = TW'((c + $signed(CW'(vrr_pkg::HALF_Q14))) >>> 14);
              wt_d[a][0] = 16'(vrr_pkg::ONE_Q14);
            end
            vrr_pkg::MODE_LINEAR: begin
              first_d[a] = TW'(c >>> 14);
              wt_d[a][0] = 16'(vrr_pkg::ONE_Q14) - 16'(c[13:0]);
              wt_d[a][1] = 16'(c[13:0]);
            end
            default: begin
              first_d[a] = TW'(c >>> 14) - 16'sd1;
            end
          endcase
        end
        ax_d = 2'd0;
        tm_d = 2'd0;
        state_d = (mode_q == vrr_pkg::MODE_NEAREST || mode_q == vrr_pkg::MODE_LINEAR) ?
                  vrr_pkg::ST_ADR : vrr_pkg::ST_KA;
      end
      // keys weight, first product: a*a or a*(5-a)
      vrr_pkg::ST_KA: begin
        mul_x = XW'(ka);
        mul_y = br1 ? 18'(ka) : 18'(17'(vrr_pkg::FIVE_Q14) - ka);
        acc_d = mul_p;
        state_d = vrr_pkg::ST_KB;
      end
      vrr_pkg::ST_KB: begin
        if (br1) begin
          mul_x = XW'(acc_q);
          mul_y = 18'(19'sd3 * $signed({2'b00, ka}) - 19'sd81920);
          num = mul_p + C43;
        end else begin
          mul_x = XW'(acc_q - C31);
          mul_y = 18'($signed({1'b0, ka}));
          num = mul_p + C44;
        end
        wt_d[ax_q][tm_q] = 16'((num + C28) >>> 29);
        tm_d = tm_q + 2'd1;
        state_d = vrr_pkg::ST_KA;
        if (tm_q == 2'd3) begin
          ax_d = ax_q + 2'd1;
          if (ax_q == 2'd2) begin
            state_d = vrr_pkg::ST_ADR;
          end
        end
      end
      // first tap address, kept modulo the address width
      vrr_pkg::ST_ADR: begin
        case (tm_q)
          2'd0: begin
            mul_x = XW'(dim_h);
            mul_y = 18'(dim_w);
            hw_d = 17'(mul_p);
            tm_d = 2'd1;
          end
          2'd1: begin
            mul_x = XW'(first_q[0] - 16'sd1);
            mul_y = 18'(dim_h);
            addrz_d = ADDR_W'(first_q[1] - 16'sd1) + ADDR_W'(mul_p);
            tm_d = 2'd2;
          end
          default: begin
            mul_x = XW'(first_q[2] - 16'sd1);
            mul_y = 18'(hw_q);
            addrz_d = addrz_q + ADDR_W'(mul_p);
            addrx_d = addrz_d;
            addr_d = addrz_d;
            accz_d = '0;
            ti_d = 2'd0;
            tj_d = 2'd0;
            tk_d = 2'd0;
            tm_d = 2'd0;
            state_d = vrr_pkg::ST_RD;
          end
        endcase
      end
      vrr_pkg::ST_RD: begin
        accy_d = '0;
        if (tj_q == 2'd0) begin
          accx_d = '0;
        end
        state_d = vrr_pkg::ST_MY;
      end
      vrr_pkg::ST_MY: begin
        mul_x = ins_q ? XW'(rdata) : XW'(fill_q);
        mul_y = 18'(wt_q[1][ti_q]);
        accy_d = accy_q + mul_p;
        // the next y tap is read while this one is accumulated
        si = ti_q + 2'd1;
        rd_addr = addr_q + ADDR_W'(1);
        if (ti_q != last_tap) begin
          ti_d = ti_q + 2'd1;
          addr_d = addr_q + ADDR_W'(1);
        end else begin
          ti_d = 2'd0;
          state_d = vrr_pkg::ST_MX;
        end
      end
      vrr_pkg::ST_MX: begin
        mul_x = XW'(accy_q);
        mul_y = 18'(wt_q[0][tj_q]);
        accx_d = accx_q + mul_p;
        if (tj_q != last_tap) begin
          tj_d = tj_q + 2'd1;
          addrx_d = addrx_q + ADDR_W'(dim_h);
          addr_d = addrx_d;
          state_d = vrr_pkg::ST_RD;
        end else begin
          tj_d = 2'd0;
          state_d = vrr_pkg::ST_MR;
        end
      end
      vrr_pkg::ST_MR: begin
        sxy_d = XW'((accx_q + C13) >>> 14);
        state_d = vrr_pkg::ST_MZ;
      end
      vrr_pkg::ST_MZ: begin
        mul_x = sxy_q;
        mul_y = 18'(wt_q[2][tk_q]);
        accz_d = accz_q + mul_p;
        if (tk_q != last_tap) begin
          tk_d = tk_q + 2'd1;
          addrz_d = addrz_q + ADDR_W'(hw_q);
          addrx_d = addrz_d;
          addr_d = addrz_d;
          state_d = vrr_pkg::ST_RD;
        end else begin
          state_d = vrr_pkg::ST_FIN;
        end
      end
      vrr_pkg::ST_FIN: begin
        rres = (accz_q + C27) >>> 28;
        if (rres < 0) begin
          rsv_d = 16'd0;
          rcl_d = 1'b1;
        end else if (rres > VMAX) begin
          rsv_d = 16'(VMAX);
          rcl_d = 1'b1;
        end else begin
          rsv_d = 16'(rres);
          rcl_d = 1'b0;
        end
        state_d = vrr_pkg::ST_DONE;
      end
      vrr_pkg::ST_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d = 1'b1;
          osv_d = rsv_q;
          ocl_d = rcl_q;
          state_d = vrr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vrr_pkg::ST_IDLE;
      end
    endcase

    // bounds check of the tap being read
    tx = (TW+1)'(first_q[0]) + (TW+1)'(tj_q);
    ty = (TW+1)'(first_q[1]) + (TW+1)'(si);
    tz = (TW+1)'(first_q[2]) + (TW+1)'(tk_q);
    ins_d = (tx > 0) && (tx <= $signed((TW+1)'(dim_w)))
         && (ty > 0) && (ty <= $signed((TW+1)'(dim_h)))
         && (tz > 0) && (tz <= $signed((TW+1)'(dim_d)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= vrr_pkg::ST_IDLE;
      ov_q      <= 1'b0;
      ax_q      <= 2'd0;
      tm_q      <= 2'd0;
      ti_q      <= 2'd0;
      tj_q      <= 2'd0;
      tk_q      <= 2'd0;
      rotx_q    <= vrr_pkg::ROT_X_RESET;
      roty_q    <= vrr_pkg::ROT_Y_RESET;
      rotz_q    <= vrr_pkg::ROT_Z_RESET;
      indims_q  <= vrr_pkg::DIMS_RESET;
      outdims_q <= vrr_pkg::DIMS_RESET;
      mode_q    <= vrr_pkg::MODE_LINEAR;
      fill_q    <= 16'd0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      ax_q    <= ax_d;
      tm_q    <= tm_d;
      ti_q    <= ti_d;
      tj_q    <= tj_d;
      tk_q    <= tk_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          vrr_pkg::CFG_ROT_X:    rotx_q    <= cfg_data_i;
          vrr_pkg::CFG_ROT_Y:    roty_q    <= cfg_data_i;
          vrr_pkg::CFG_ROT_Z:    rotz_q    <= cfg_data_i;
          vrr_pkg::CFG_IN_DIMS:  indims_q  <= cfg_data_i[23:0];
          vrr_pkg::CFG_OUT_DIMS: outdims_q <= cfg_data_i[23:0];
          vrr_pkg::CFG_MODE:     mode_q    <= cfg_data_i[1:0];
          vrr_pkg::CFG_FILL:     fill_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d2_q    <= d2_d;
    acc_q   <= acc_d;
    coord_q <= coord_d;
    first_q <= first_d;
    wt_q    <= wt_d;
    hw_q    <= hw_d;
    addrz_q <= addrz_d;
    addrx_q <= addrx_d;
    addr_q  <= addr_d;
    accy_q  <= accy_d;
    accx_q  <= accx_d;
    accz_q  <= accz_d;
    sxy_q   <= sxy_d;
    rsv_q   <= rsv_d;
    rcl_q   <= rcl_d;
    osv_q   <= osv_d;
    ocl_q   <= ocl_d;
    ins_q   <= ins_d;
  end

  vrr_voxel_ram #(
    .DEPTH  (STORE),
    .ADDR_W (ADDR_W),
    .DATA_W (VOXEL_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ADDR_W'(in_i.voxel_addr)),
    .wdata_i (VOXEL_BITS'(in_i.voxel_value)),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

endmodule

`default_nettype wire

/* verif/tb_volume_rotate_resampler.sv */
// tb_volume_rotate_resampler: self-checking bench for the voxel volume rotate resampler
// predicts each resampled word in fixed point and compares it with the block's output
// depends on vrr_pkg, vrr_if and the volume_rotate_resampler rtl
`timescale 1ns / 100ps

module tb_volume_rotate_resampler;

  typedef struct packed {
    logic [15:0] value;
    logic        clipped;
  } sample_t;

  localparam longint Q14 = 16384;
  localparam longint DIM_CAP = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [47:0] cfg_data_i;

  vrr_in_if in_ch ();
  vrr_out_if out_ch ();

  volume_rotate_resampler DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_ch),
    .out_o(out_ch),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the block's registers and voxel memory
  logic [47:0] rot_q[3];
  logic [23:0] in_dims_q, out_dims_q;
  logic [1:0] mode_q;
  logic [15:0] fill_q;
  logic [15:0] voxel_mem[int];

  sample_t expected_samples[$];
  int mismatches = 0;
  int loads_sent = 0;
  int samples_sent = 0;
  int clipped_seen = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;

  function automatic longint keys_weight(longint a);
    longint num;
    if (a < Q14)
      num = 3 * a * a * a - 5 * Q14 * a * a + (longint'(1) << 43);
    else if (a < 2 * Q14)
      num = -a * a * a + 5 * Q14 * a * a - 8 * (longint'(1) << 28) * a + (longint'(1) << 44);
    else
      return 0;
    return (num + (longint'(1) << 28)) >>> 29;
  endfunction

  function automatic int axis_taps(longint c, int mode, output longint first,
                                   output longint w[4]);
    longint i0, f, d;
    w = '{0, 0, 0, 0};
    if (mode == 0) begin
      first = (c + Q14 / 2) >>> 14;
      w[0] = Q14;
      return 1;
    end
    i0 = c >>> 14;
    f = c - i0 * Q14;
    if (mode == 1) begin
      first = i0;
      w[0] = Q14 - f;
      w[1] = f;
      return 2;
    end
    first = i0 - 1;
    for (int k = -1; k <= 2; k++) begin
      d = longint'(k) * Q14 - f;
      w[k + 1] = keys_weight(d < 0 ? -d : d);
    end
    return 4;
  endfunction

  function automatic longint voxel_at(longint x, longint y, longint z, longint h,
                                      longint wd, longint dp);
    int idx;
    if (x < 1 || x > wd || y < 1 || y > h || z < 1 || z > dp)
      return longint'(fill_q);
    idx = int'((y - 1) + (x - 1) * h + (z - 1) * h * wd);
    return voxel_mem.exists(idx) ? longint'(voxel_mem[idx]) : 0;
  endfunction

  function automatic sample_t resample(logic [7:0] col, logic [7:0] row, logic [7:0] page);
    longint dim[3], del[3], coord[3];
    longint fx, fy, fz, wx[4], wy[4], wz[4];
    longint v15, acc_x, acc_y, acc_z, sxy, res;
    int nx, ny, nz, mode;
    sample_t s;
    dim[0] = longint'(in_dims_q[15:8]);
    dim[1] = longint'(in_dims_q[23:16]);
    dim[2] = longint'(in_dims_q[7:0]);
    for (int i = 0; i < 3; i++)
      if (dim[i] > DIM_CAP) dim[i] = DIM_CAP;
    del[0] = 2 * longint'(col) - longint'(out_dims_q[15:8]) - 1;
    del[1] = 2 * longint'(row) - longint'(out_dims_q[23:16]) - 1;
    del[2] = 2 * longint'(page) - longint'(out_dims_q[7:0]) - 1;
    for (int i = 0; i < 3; i++) begin
      v15 = (dim[i] + 1) * Q14;
      for (int j = 0; j < 3; j++)
        v15 += longint'($signed(rot_q[i][47 - 16 * j -: 16])) * del[j];
      coord[i] = (v15 + 1) >>> 1;
    end
    mode = (mode_q == vrr_pkg::MODE_NEAREST) ? 0 : (mode_q == vrr_pkg::MODE_LINEAR) ? 1 : 2;
    nx = axis_taps(coord[0], mode, fx, wx);
    ny = axis_taps(coord[1], mode, fy, wy);
    nz = axis_taps(coord[2], mode, fz, wz);
    acc_z = 0;
    for (int k = 0; k < nz; k++) begin
      acc_x = 0;
      for (int j = 0; j < nx; j++) begin
        acc_y = 0;
        for (int i = 0; i < ny; i++)
          acc_y += wy[i] * voxel_at(fx + j, fy + i, fz + k, dim[1], dim[0], dim[2]);
        acc_x += wx[j] * acc_y;
      end
      sxy = (acc_x + (longint'(1) << 13)) >>> 14;
      acc_z += wz[k] * sxy;
    end
    res = (acc_z + (longint'(1) << 27)) >>> 28;
    if (res < 0) s = '{value: 16'h0000, clipped: 1'b1};
    else if (res > 65535) s = '{value: 16'hFFFF, clipped: 1'b1};
    else s = '{value: res[15:0], clipped: 1'b0};
    return s;
  endfunction

  // one word on the input channel; the prediction is made at acceptance
  task automatic send_word(logic kind, logic [17:0] addr, logic [15:0] value,
                           logic [7:0] col, logic [7:0] row, logic [7:0] page);
    sample_t s;
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.voxel_addr <= addr;
    in_ch.voxel_value <= value;
    in_ch.out_col <= col;
    in_ch.out_row <= row;
    in_ch.out_page <= page;
    do @(posedge clk_i); while (!in_ch.ready);
    if (kind) begin
      s = resample(col, row, page);
      expected_samples.push_back(s);
      samples_sent++;
      if (s.clipped) clipped_seen++;
    end else begin
      voxel_mem[int'(addr)] = value;
      loads_sent++;
    end
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
      @(posedge clk_i);
    end
  endtask

  task automatic load_voxel(int addr, logic [15:0] value);
    send_word(1'b0, addr[17:0], value, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic request_sample(logic [7:0] col, logic [7:0] row, logic [7:0] page);
    send_word(1'b1, 18'($urandom), 16'($urandom), col, row, page);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic program_regs(logic [47:0] rx, logic [47:0] ry, logic [47:0] rz,
                              logic [23:0] ind, logic [23:0] outd, logic [1:0] mode,
                              logic [15:0] fill);
    write_reg(vrr_pkg::CFG_ROT_X, rx);
    write_reg(vrr_pkg::CFG_ROT_Y, ry);
    write_reg(vrr_pkg::CFG_ROT_Z, rz);
    write_reg(vrr_pkg::CFG_IN_DIMS, {24'd0, ind});
    write_reg(vrr_pkg::CFG_OUT_DIMS, {24'd0, outd});
    write_reg(vrr_pkg::CFG_MODE, {46'd0, mode});
    write_reg(vrr_pkg::CFG_FILL, {32'd0, fill});
    cfg_we_i <= 1'b0;
    rot_q = '{rx, ry, rz};
    in_dims_q = ind;
    out_dims_q = outd;
    mode_q = mode;
    fill_q = fill;
  endtask

  function automatic logic [15:0] random_voxel();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_entry(bit wild);
    if (wild) return 16'($urandom);
    return 16'($urandom_range(2 * Q14) - Q14);
  endfunction

  // small volume in a 2 x 3 x 2 box, walked through every filter
  task automatic test_directed();
    logic [15:0] vals[12] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF,
                              16'h0000, 16'hFFFF, 16'h1234, 16'h0000, 16'hFFFF, 16'hFFFE};
    program_regs(vrr_pkg::ROT_X_RESET, vrr_pkg::ROT_Y_RESET, vrr_pkg::ROT_Z_RESET,
                 24'h02_03_02, 24'h02_03_02, vrr_pkg::MODE_NEAREST, 16'hABCD);
    for (int a = 0; a < 12; a++) load_voxel(a, vals[a]);
    request_sample(8'd1, 8'd1, 8'd1);
    request_sample(8'd3, 8'd2, 8'd2);
    request_sample(8'd0, 8'd0, 8'd0);
    request_sample(8'd255, 8'd255, 8'd255);
    wait_idle();
    // half-voxel steps in x
    program_regs({16'h2000, 16'h2000, 16'h0000}, vrr_pkg::ROT_Y_RESET, vrr_pkg::ROT_Z_RESET,
                 24'h02_03_02, 24'h02_03_02, vrr_pkg::MODE_LINEAR, 16'h0000);
    request_sample(8'd2, 8'd1, 8'd1);
    request_sample(8'd3, 8'd2, 8'd2);
    wait_idle();
    // the cubic kernel sampled at voxel centres gives back the stored voxels
    program_regs(vrr_pkg::ROT_X_RESET, vrr_pkg::ROT_Y_RESET, vrr_pkg::ROT_Z_RESET,
                 24'h02_03_02, 24'h02_03_02, vrr_pkg::MODE_CUBIC, 16'hFFFF);
    request_sample(8'd2, 8'd1, 8'd1);
    request_sample(8'd2, 8'd2, 8'd1);
    request_sample(8'd3, 8'd1, 8'd2);
    wait_idle();
    program_regs({16'h2000, 16'h0000, 16'h1000}, vrr_pkg::ROT_Y_RESET, vrr_pkg::ROT_Z_RESET,
                 24'h02_03_02, 24'h02_03_02, vrr_pkg::MODE_RESERVED, 16'h0000);
    request_sample(8'd2, 8'd2, 8'd1);
    wait_idle();
    // most negative and most positive matrix entries
    program_regs({16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h7FFF},
                 {16'h8000, 16'h8000, 16'h7FFF}, 24'h02_03_02, 24'h80_80_80,
                 vrr_pkg::MODE_LINEAR, 16'h5A5A);
    request_sample(8'd1, 8'd1, 8'd1);
    request_sample(8'd128, 8'd128, 8'd128);
    wait_idle();
    // empty input volume gives the fill everywhere
    program_regs(vrr_pkg::ROT_X_RESET, vrr_pkg::ROT_Y_RESET, vrr_pkg::ROT_Z_RESET,
                 24'h00_03_02, 24'h02_03_02, vrr_pkg::MODE_LINEAR, 16'h0F0F);
    request_sample(8'd1, 8'd2, 8'd1);
    wait_idle();
  endtask

  // oversized dims cap at 64; identity keeps in-volume taps in the loaded 5-cube corner
  task automatic test_full_size();
    for (int z = 0; z < 5; z++)
      for (int x = 0; x < 5; x++)
        for (int y = 0; y < 5; y++)
          load_voxel(y + x * 64 + z * 4096, random_voxel());
    for (int m = 0; m < 3; m++) begin
      wait_idle();
      program_regs(vrr_pkg::ROT_X_RESET, vrr_pkg::ROT_Y_RESET, vrr_pkg::ROT_Z_RESET,
                   24'hFF_FF_FF, vrr_pkg::DIMS_RESET, 2'(m), 16'($urandom));
      repeat (4)
        request_sample(8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
                       8'($urandom_range(1, 3)));
    end
    wait_idle();
  endtask

  // random box, random matrix, every in-box voxel loaded before any sample
  task automatic test_random_setup(int n_samples, bit wide_out);
    logic [7:0] h, w, d, oh, ow, od;
    bit wild;
    h = 8'($urandom_range(1, 4));
    w = 8'($urandom_range(1, 4));
    d = 8'($urandom_range(1, 4));
    if ($urandom_range(9) == 0) d = 8'd0;
    oh = wide_out ? 8'($urandom) : 8'($urandom_range(1, 8));
    ow = wide_out ? 8'($urandom) : 8'($urandom_range(1, 8));
    od = wide_out ? 8'($urandom) : 8'($urandom_range(1, 8));
    wild = ($urandom_range(3) == 0);
    wait_idle();
    program_regs({random_entry(wild), random_entry(wild), random_entry(wild)},
                 {random_entry(wild), random_entry(wild), random_entry(wild)},
                 {random_entry(wild), random_entry(wild), random_entry(wild)},
                 {h, w, d}, {oh, ow, od}, 2'($urandom_range(3)), random_voxel());
    for (int a = 0; a < int'(h) * int'(w) * int'(d); a++) load_voxel(a, random_voxel());
    for (int n = 0; n < n_samples; n++) begin
      if ($urandom_range(7) == 0) load_voxel(int'($urandom_range(262143)), random_voxel());
      if ($urandom_range(7) == 0)
        request_sample(8'($urandom), 8'($urandom), 8'($urandom));
      else
        request_sample(8'($urandom_range(0, int'(ow) + 1)),
                       8'($urandom_range(0, int'(oh) + 1)),
                       8'($urandom_range(0, int'(od) + 1)));
    end
  endtask

  // the receiver holds off while samples keep coming, so the input stalls
  task automatic test_backpressure();
    test_random_setup(0, 1'b0);
    hold_left = 400;
    repeat (20)
      request_sample(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                     8'($urandom_range(1, 4)));
  endtask

  task automatic note_mismatch(sample_t exp_s, sample_t act_s);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch: expected value %04h clipped %0b, got value %04h clipped %0b",
               exp_s.value, exp_s.clipped, act_s.value, act_s.clipped);
  endtask

  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: result word with none expected");
      end else if (expected_samples[0] !== sample_t'({out_ch.sample_value, out_ch.clipped}))
        note_mismatch(expected_samples.pop_front(),
                      sample_t'({out_ch.sample_value, out_ch.clipped}));
      else
        void'(expected_samples.pop_front());
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.voxel_addr = '0;
    in_ch.voxel_value = '0;
    in_ch.out_col = '0;
    in_ch.out_row = '0;
    in_ch.out_page = '0;
    out_ch.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_size();
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 84 : 0;
      rx_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 38 : 0;
      for (int s = 0; s < 3; s++) test_random_setup(12, s == 2);
    end
    test_backpressure();
    wait_idle();
    $display("ran %0d voxel loads and %0d sample words (%0d saturated)", loads_sent,
             samples_sent, clipped_seen);
    $display("nearest, trilinear and cubic filters under random matrices and stalls");
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/vrr_pkg.sv
rtl/vrr_if.sv
rtl/vrr_voxel_ram.sv
rtl/volume_rotate_resampler.sv
verif/tb_volume_rotate_resampler.sv
